/* sv/sdf_pkg.sv */
`timescale 1ns / 1ps
// shared types and constants of the stream duplicate filter
// no dependencies; used by every other file of the block but sdf_ram

package sdf_pkg;

	localparam int TableDepthDefault = 32;
	localparam int ValueW            = 32;
	localparam int DupW              = 16;
	localparam int UcountW           = 6;
	localparam int UcountMax         = 63;
	localparam logic [DupW-1:0] DupMax = '1;

	typedef struct packed {
		logic signed [ValueW-1:0] item_value;
		logic                     is_duplicate;
		logic                     table_full;
		logic [UcountW-1:0]       unique_count;
		logic [DupW-1:0]          dup_count;
	} sdf_result_t;

endpackage

/* sv/sdf_stream_if.sv */
`timescale 1ns / 1ps
// valid/ready channels of the stream duplicate filter
// field widths come from sdf_pkg

interface sdf_in_if;
	logic                             valid;
	logic                             ready;
	logic signed [sdf_pkg::ValueW-1:0] value;
	logic                             first_item;

	modport source (output valid, output value, output first_item, input ready);
	modport sink (input valid, input value, input first_item, output ready);
endinterface

interface sdf_out_if;
	logic                              valid;
	logic                              ready;
	logic signed [sdf_pkg::ValueW-1:0] item_value;
	logic                              is_duplicate;
	logic                              table_full;
	logic [sdf_pkg::UcountW-1:0]       unique_count;
	logic [sdf_pkg::DupW-1:0]          dup_count;

	modport source (output valid, output item_value, output is_duplicate,
		output table_full, output unique_count, output dup_count, input ready);
	modport sink (input valid, input item_value, input is_duplicate,
		input table_full, input unique_count, input dup_count, output ready);
endinterface

/* sv/sdf_ram.sv */
`timescale 1ns / 1ps
// generic single-write, single-read ram with registered read data
// no dependencies

module sdf_ram #(
	parameter int Width = 32,
	parameter int Depth = 32
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(Depth)-1:0] waddr,
	input  logic [Width-1:0]         wdata,
	input  logic [$clog2(Depth)-1:0] raddr,
	output logic [Width-1:0]         rdata
);

	logic [Width-1:0] mem_q [Depth];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

/* sv/sdf_seq.sv */
`timescale 1ns / 1ps
// sequencer of the duplicate filter: scans the seen table one entry per cycle
// through a shared comparator, then stores, counts or flags full; uses sdf_pkg

module sdf_seq #(
	parameter int TABLE_DEPTH = sdf_pkg::TableDepthDefault
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               in_valid,
	input  logic signed [sdf_pkg::ValueW-1:0]  in_value,
	input  logic                               in_first,
	output logic                               in_ready,
	input  logic                               slot_free,
	output logic                               res_valid,
	output sdf_pkg::sdf_result_t               res,
	output logic                               ram_we,
	output logic [$clog2(TABLE_DEPTH)-1:0]     ram_waddr,
	output logic [sdf_pkg::ValueW-1:0]         ram_wdata,
	output logic [$clog2(TABLE_DEPTH)-1:0]     ram_raddr,
	input  logic [sdf_pkg::ValueW-1:0]         ram_rdata
);

	localparam int AW = $clog2(TABLE_DEPTH);
	localparam int CW = $clog2(TABLE_DEPTH + 1);

	typedef enum logic [2:0] {
		ST_IDLE   = 3'b001,
		ST_SCAN   = 3'b010,
		ST_FINISH = 3'b100
	} state_t;

	state_t                            state_q, state_d;
	logic signed [sdf_pkg::ValueW-1:0] value_q;
	logic [CW-1:0]                     cnt_q;
	logic [CW-1:0]                     ridx_q;
	logic [sdf_pkg::DupW-1:0]          dup_q;
	logic                              cmp_vld_q;
	logic                              hit_q;

	logic          hit_now;
	logic          issue;
	logic          scan_done;
	logic          accept;
	logic          emit;
	logic          is_full;
	logic [CW-1:0] cnt_new;
	logic [sdf_pkg::DupW-1:0] dup_new;

	assign accept    = in_valid && in_ready;
	assign in_ready  = (state_q == ST_IDLE);
	assign hit_now   = hit_q || (cmp_vld_q && (ram_rdata == value_q));
	assign issue     = (state_q == ST_SCAN) && !hit_now && (ridx_q != cnt_q);
	// last read must have been compared before leaving the scan
	assign scan_done = !issue && (hit_now || !cmp_vld_q);
	assign emit      = (state_q == ST_FINISH) && slot_free;
	assign is_full   = (cnt_q == CW'(TABLE_DEPTH));

	assign ram_raddr = ridx_q[AW-1:0];
	assign ram_waddr = cnt_q[AW-1:0];
	assign ram_wdata = value_q;
	assign ram_we    = emit && !hit_q && !is_full;

	always_comb begin
		cnt_new = cnt_q;
		dup_new = dup_q;
		if (hit_q) begin
			if (dup_q != sdf_pkg::DupMax) begin
				dup_new = dup_q + 1'b1;
			end
		end else if (!is_full) begin
			cnt_new = cnt_q + 1'b1;
		end
	end

	always_comb begin
		res.item_value   = value_q;
		res.is_duplicate = hit_q;
		res.table_full   = !hit_q && is_full;
		res.dup_count    = dup_new;
		if (32'(cnt_new) > 32'(sdf_pkg::UcountMax)) begin
			res.unique_count = sdf_pkg::UcountW'(sdf_pkg::UcountMax);
		end else begin
			res.unique_count = sdf_pkg::UcountW'(cnt_new);
		end
	end

	assign res_valid = emit;

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (accept) state_d = ST_SCAN;
			end
			ST_SCAN: begin
				if (scan_done) state_d = ST_FINISH;
			end
			ST_FINISH: begin
				if (slot_free) state_d = ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			cnt_q     <= '0;
			dup_q     <= '0;
			ridx_q    <= '0;
			cmp_vld_q <= 1'b0;
			hit_q     <= 1'b0;
		end else begin
			state_q <= state_d;
			if (accept) begin
				// a new list empties the table before the lookup
				if (in_first) begin
					cnt_q <= '0;
					dup_q <= '0;
				end
				ridx_q    <= '0;
				cmp_vld_q <= 1'b0;
				hit_q     <= 1'b0;
			end else if (state_q == ST_SCAN) begin
				cmp_vld_q <= issue;
				hit_q     <= hit_now;
				if (issue) begin
					ridx_q <= ridx_q + 1'b1;
				end
			end else if (emit) begin
				cnt_q <= cnt_new;
				dup_q <= dup_new;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			value_q <= in_value;
		end
	end

endmodule

/* sv/stream_duplicate_filter.sv */
`timescale 1ns / 1ps
// an item's result goes to the result register once the scan of the stored values of
// its list ends (early when a match is found) and the result register is free
// one item at a time: the next item is accepted only after the previous result is emitted;
// the result register lets the next item in while a result waits
// reset clears counts and control; table contents stay undefined, only entries
// below the stored count are read

module stream_duplicate_filter #(
	parameter int TABLE_DEPTH = sdf_pkg::TableDepthDefault
) (
	input logic    clk,
	input logic    arst_n,
	sdf_in_if.sink   din,
	sdf_out_if.source dout
);

	localparam int AW = $clog2(TABLE_DEPTH);

	logic                         slot_free;
	logic                         res_valid;
	sdf_pkg::sdf_result_t         res;
	logic                         ram_we;
	logic [AW-1:0]                ram_waddr;
	logic [sdf_pkg::ValueW-1:0]   ram_wdata;
	logic [AW-1:0]                ram_raddr;
	logic [sdf_pkg::ValueW-1:0]   ram_rdata;
	logic                         out_vld_q;
	sdf_pkg::sdf_result_t         out_res_q;

	sdf_seq #(
		.TABLE_DEPTH (TABLE_DEPTH)
	) u_seq (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (din.valid),
		.in_value  (din.value),
		.in_first  (din.first_item),
		.in_ready  (din.ready),
		.slot_free (slot_free),
		.res_valid (res_valid),
		.res       (res),
		.ram_we    (ram_we),
		.ram_waddr (ram_waddr),
		.ram_wdata (ram_wdata),
		.ram_raddr (ram_raddr),
		.ram_rdata (ram_rdata)
	);

	sdf_ram #(
		.Width (sdf_pkg::ValueW),
		.Depth (TABLE_DEPTH)
	) u_seen (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	assign slot_free = !out_vld_q || dout.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q <= 1'b0;
		end else if (res_valid) begin
			out_vld_q <= 1'b1;
		end else if (dout.ready) begin
			out_vld_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (res_valid) begin
			out_res_q <= res;
		end
	end

	assign dout.valid        = out_vld_q;
	assign dout.item_value   = out_res_q.item_value;
	assign dout.is_duplicate = out_res_q.is_duplicate;
	assign dout.table_full   = out_res_q.table_full;
	assign dout.unique_count = out_res_q.unique_count;
	assign dout.dup_count    = out_res_q.dup_count;

endmodule

/* sv/sdf_checker.sv */
`timescale 1ns / 1ps
// port-level checks of the stream duplicate filter, bound to the top level
// uses field widths from sdf_pkg

module sdf_checker (
	input logic                        clk,
	input logic                        arst_n,
	input logic                        in_valid,
	input logic                        in_ready,
	input logic                        out_valid,
	input logic                        out_ready,
	input logic                        is_duplicate,
	input logic                        table_full,
	input logic [sdf_pkg::UcountW-1:0] unique_count
);

	// a result waits until it is taken
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid)
		else $error("result dropped before it was taken");

	// one item at a time: no new item right after one is taken
	a_one_at_a_time: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("item taken while the previous one is in the scan");

	a_flags_exclusive: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> !(is_duplicate && table_full))
		else $error("duplicate and table full flagged together");

	// a stored new value leaves at least one entry in the table
	a_stored_counts: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !is_duplicate && !table_full |-> unique_count != '0)
		else $error("new value stored but unique count is zero");

endmodule

bind stream_duplicate_filter sdf_checker u_sdf_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.in_valid     (din.valid),
	.in_ready     (din.ready),
	.out_valid    (dout.valid),
	.out_ready    (dout.ready),
	.is_duplicate (dout.is_duplicate),
	.table_full   (dout.table_full),
	.unique_count (dout.unique_count)
);
